/* hw/rtl/cde_pkg.sv */
// Shared types and constants for the capped site/domain event counter.
// Depends on nothing; imported by every module of the block.
package cde_pkg;

	localparam int SITE_SLOTS   = 4;
	localparam int DOMAIN_SLOTS = 16;
	localparam int SITE_W       = 2;
	localparam int DSLOT_W      = 4;
	localparam int ENT_W        = SITE_W + DSLOT_W;
	localparam int ENTRIES      = SITE_SLOTS * DOMAIN_SLOTS;
	localparam int CNT_W        = 32;
	localparam int TOT_W        = 48;
	localparam int CMDQ_DEPTH   = 2;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_DELTA = 2'd1;
	localparam logic [1:0] FUNC_DRAIN = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	localparam logic [2:0] ST_DETECTED   = 3'd0;
	localparam logic [2:0] ST_BLOCKED    = 3'd1;
	localparam logic [2:0] ST_ALLOWED    = 3'd2;
	localparam logic [2:0] ST_RANDOMIZED = 3'd3;

	localparam logic KIND_DELTA = 1'b0;
	localparam logic KIND_ROW   = 1'b1;

	// Classified command: bump is one-hot over detected/blocked/allowed/randomized,
	// all zero for potential or unknown status.
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] site;
		logic [31:0] key;
		logic [3:0]  bump;
		logic [31:0] day;
	} cmd_t;

	typedef struct packed {
		logic             kind;
		logic [31:0]      day;
		logic [31:0]      site;
		logic [31:0]      domain;
		logic [TOT_W-1:0] det;
		logic [TOT_W-1:0] blk;
		logic [TOT_W-1:0] alw;
		logic [TOT_W-1:0] rnd;
		logic [31:0]      drop;
		logic [31:0]      fold;
		logic             last;
	} res_t;

endpackage

/* hw/rtl/cde_front.sv */
// Front end: accepts input beats, classifies them and queues commands.
// Depends on cde_pkg.
module cde_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic [31:0]        site_id,
	input  logic [31:0]        req_hash,
	input  logic [2:0]         status,
	input  logic [31:0]        day,
	output logic               cmd_valid,
	output cde_pkg::cmd_t      cmd,
	input  logic               cmd_take
);
	import cde_pkg::*;

	cmd_t       q_mem [CMDQ_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       in_cmd;
	logic       do_push, do_pop;

	always_comb begin
		in_cmd.func = func;
		in_cmd.site = site_id;
		in_cmd.key  = (req_hash == 32'd0) ? 32'd1 : req_hash;
		in_cmd.day  = day;
		in_cmd.bump = 4'd0;
		case (status)
			ST_DETECTED:   in_cmd.bump = 4'b0001;
			ST_BLOCKED:    in_cmd.bump = 4'b0010;
			ST_ALLOWED:    in_cmd.bump = 4'b0100;
			ST_RANDOMIZED: in_cmd.bump = 4'b1000;
			default:       in_cmd.bump = 4'd0;
		endcase
	end

	assign full      = (cnt_q == 2'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

/* hw/rtl/cde_back.sv */
// Back end: site/domain tables, counters, totals and the result register.
// Depends on cde_pkg.
module cde_back #(
	parameter int MAX_SITES   = 4,
	parameter int MAX_DOMAINS = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cde_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          res_valid,
	output cde_pkg::res_t res,
	input  logic          res_pop
);
	import cde_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SITE  = 4'd1;
	localparam logic [3:0] S_ARD   = 4'd2;
	localparam logic [3:0] S_ACMP  = 4'd3;
	localparam logic [3:0] S_DL1   = 4'd4;
	localparam logic [3:0] S_DL2   = 4'd5;
	localparam logic [3:0] S_DNEXT = 4'd6;
	localparam logic [3:0] S_DEMIT = 4'd7;

	localparam logic [2:0] MAXS = 3'(MAX_SITES);
	localparam logic [4:0] MAXD = 5'(MAX_DOMAINS);

	logic [3:0]        state_q;
	cmd_t              cur_q;
	logic [31:0]       site_key_q [SITE_SLOTS];
	logic [2:0]        site_used_q;
	logic [4:0]        dom_used_q [SITE_SLOTS];
	logic [TOT_W-1:0]  total_q [4];
	logic [TOT_W-1:0]  wm_q [4];
	logic [TOT_W-1:0]  diff_q [4];
	logic [31:0]       drop_q, fold_q;
	logic [SITE_W-1:0] idx_q;
	logic [2:0]        s_q;
	logic [4:0]        d_q;
	logic [31:0]       key_q;
	logic              folding_q;
	logic              last_q;
	logic              res_v_q;
	res_t              res_q;

	// entry memories
	logic [31:0]    mem_key [ENTRIES];
	logic [CNT_W-1:0] mem_cnt [4][ENTRIES];
	logic [31:0]    rd_key;
	logic [CNT_W-1:0] rd_cnt [4];
	logic           rd_en, wr_en;
	logic [ENT_W-1:0] rd_addr, wr_addr;
	logic [31:0]    wr_key;
	logic [CNT_W-1:0] wr_cnt [4];

	logic [SITE_SLOTS-1:0] hit;
	logic [SITE_W-1:0]     hit_idx;
	logic [4:0]            cur_used;
	logic                  out_free;
	logic                  res_load;

	always_comb begin
		hit     = '0;
		hit_idx = '0;
		for (int i = SITE_SLOTS - 1; i >= 0; i--) begin
			if (3'(i) < site_used_q && site_key_q[i] == cur_q.site) begin
				hit[i]  = 1'b1;
				hit_idx = SITE_W'(i);
			end
		end
	end

	assign cur_used = dom_used_q[idx_q];
	assign out_free = !res_v_q || res_pop;
	assign res_load = ((state_q == S_DL2) || (state_q == S_DEMIT)) && out_free;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {idx_q, d_q[DSLOT_W-1:0]};
		wr_en   = 1'b0;
		wr_addr = {idx_q, d_q[DSLOT_W-1:0]};
		wr_key  = key_q;
		for (int i = 0; i < 4; i++) begin
			wr_cnt[i] = 32'(cur_q.bump[i]);
		end
		case (state_q)
			S_ARD: begin
				if (d_q == cur_used) begin
					if (!(!folding_q && cur_used >= MAXD)) wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			S_ACMP: begin
				wr_addr = {idx_q, d_q[DSLOT_W-1:0]};
				wr_en   = (rd_key == key_q);
				for (int i = 0; i < 4; i++) begin
					wr_cnt[i] = (cur_q.bump[i] && rd_cnt[i] != '1) ? rd_cnt[i] + 32'd1
						: rd_cnt[i];
				end
			end
			S_DNEXT: begin
				rd_addr = {s_q[SITE_W-1:0], d_q[DSLOT_W-1:0]};
				rd_en   = (s_q != site_used_q) && (d_q != dom_used_q[s_q[SITE_W-1:0]]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_key[wr_addr] <= wr_key;
			for (int i = 0; i < 4; i++) mem_cnt[i][wr_addr] <= wr_cnt[i];
		end
		if (rd_en) begin
			rd_key <= mem_key[rd_addr];
			for (int i = 0; i < 4; i++) rd_cnt[i] <= mem_cnt[i][rd_addr];
		end
	end

	always_comb begin
		cmd_take = (state_q == S_IDLE) && cmd_valid;
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_SITE && hit == '0 && site_used_q < MAXS) begin
			site_key_q[site_used_q[SITE_W-1:0]] <= cur_q.site;
		end
		if (state_q == S_IDLE && cmd_valid) cur_q <= cmd;
		if (state_q == S_DL1) begin
			for (int i = 0; i < 4; i++) diff_q[i] <= total_q[i] - wm_q[i];
		end
		if (state_q == S_DL2 && out_free) begin
			res_q.kind   <= KIND_DELTA;
			res_q.day    <= '0;
			res_q.site   <= '0;
			res_q.domain <= '0;
			res_q.det    <= diff_q[0] + diff_q[2];
			res_q.blk    <= diff_q[1];
			res_q.alw    <= '0;
			res_q.rnd    <= diff_q[3];
			res_q.drop   <= drop_q;
			res_q.fold   <= fold_q;
			res_q.last   <= 1'b1;
		end
		if (state_q == S_DEMIT && out_free) begin
			res_q.kind   <= KIND_ROW;
			res_q.day    <= cur_q.day;
			res_q.site   <= site_key_q[s_q[SITE_W-1:0]];
			res_q.domain <= rd_key;
			res_q.det    <= TOT_W'(rd_cnt[0]);
			res_q.blk    <= TOT_W'(rd_cnt[1]);
			res_q.alw    <= TOT_W'(rd_cnt[2]);
			res_q.rnd    <= TOT_W'(rd_cnt[3]);
			res_q.drop   <= drop_q;
			res_q.fold   <= fold_q;
			res_q.last   <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			site_used_q <= '0;
			for (int i = 0; i < SITE_SLOTS; i++) dom_used_q[i] <= '0;
			for (int i = 0; i < 4; i++) begin
				total_q[i] <= '0;
				wm_q[i]    <= '0;
			end
			drop_q    <= '0;
			fold_q    <= '0;
			idx_q     <= '0;
			s_q       <= '0;
			d_q       <= '0;
			key_q     <= '0;
			folding_q <= 1'b0;
			last_q    <= 1'b0;
			res_v_q   <= 1'b0;
		end else begin
			// result register: loaded by a delta or row beat, freed by a pop
			res_v_q <= res_load || (res_v_q && !res_pop);
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						d_q <= '0;
						s_q <= '0;
						case (cmd.func)
							FUNC_ADD:   state_q <= S_SITE;
							FUNC_DELTA: state_q <= S_DL1;
							FUNC_DRAIN: state_q <= S_DNEXT;
							FUNC_CLEAR: begin
								site_used_q <= '0;
								for (int i = 0; i < SITE_SLOTS; i++) dom_used_q[i] <= '0;
								for (int i = 0; i < 4; i++) begin
									total_q[i] <= '0;
									wm_q[i]    <= '0;
								end
								drop_q <= '0;
								fold_q <= '0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SITE: begin
					for (int i = 0; i < 4; i++) begin
						if (cur_q.bump[i]) total_q[i] <= total_q[i] + TOT_W'(1);
					end
					key_q     <= cur_q.key;
					folding_q <= 1'b0;
					d_q       <= '0;
					if (hit != '0) begin
						idx_q   <= hit_idx;
						state_q <= S_ARD;
					end else if (site_used_q >= MAXS) begin
						drop_q  <= drop_q + 32'd1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= site_used_q[SITE_W-1:0];
						dom_used_q[site_used_q[SITE_W-1:0]] <= '0;
						site_used_q <= site_used_q + 3'd1;
						state_q <= S_ARD;
					end
				end
				S_ARD: begin
					if (d_q == cur_used) begin
						if (!folding_q && cur_used >= MAXD) begin
							folding_q <= 1'b1;
							key_q     <= '0;
							fold_q    <= fold_q + 32'd1;
							d_q       <= '0;
						end else begin
							dom_used_q[idx_q] <= cur_used + 5'd1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_ACMP;
					end
				end
				S_ACMP: begin
					if (rd_key == key_q) begin
						state_q <= S_IDLE;
					end else begin
						d_q     <= d_q + 5'd1;
						state_q <= S_ARD;
					end
				end
				S_DL1: begin
					for (int i = 0; i < 4; i++) wm_q[i] <= total_q[i];
					state_q <= S_DL2;
				end
				S_DL2: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DNEXT: begin
					if (s_q == site_used_q) begin
						site_used_q <= '0;
						for (int i = 0; i < SITE_SLOTS; i++) dom_used_q[i] <= '0;
						state_q <= S_IDLE;
					end else if (d_q == dom_used_q[s_q[SITE_W-1:0]]) begin
						s_q <= s_q + 3'd1;
						d_q <= '0;
					end else begin
						// every used site holds at least one entry
						last_q  <= (d_q + 5'd1 == dom_used_q[s_q[SITE_W-1:0]]) &&
							(s_q + 3'd1 == site_used_q);
						state_q <= S_DEMIT;
					end
				end
				S_DEMIT: begin
					if (out_free) begin
						d_q     <= d_q + 5'd1;
						state_q <= S_DNEXT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/capped_site_domain_event_counter.sv */
// Capped site/domain event counter, top level.
// An add looks up its site, then scans that site's domain entries through the registered read
// port of the entry memory until a key matches; with no match it creates an entry or, once the
// site holds MAX_DOMAINS entries, folds the event into a key-zero entry. Delta and drain wait
// while the result register is full; no new command is taken until the current one ends.
// Reset (arst_n low) empties the table, totals, watermark and drop/fold counts; no sweep.
module capped_site_domain_event_counter #(
	parameter int MAX_SITES   = 4,
	parameter int MAX_DOMAINS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [31:0] site_id,
	input  logic [31:0] req_hash,
	input  logic [2:0]  status,
	input  logic [31:0] day,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [31:0] row_day,
	output logic [31:0] row_site,
	output logic [31:0] row_domain,
	output logic [47:0] detected_count,
	output logic [47:0] blocked_count,
	output logic [47:0] allowed_count,
	output logic [47:0] randomized_count,
	output logic [31:0] dropped_site_events,
	output logic [31:0] folded_events,
	output logic        last
);
	import cde_pkg::*;

	// front queue to back engine
	logic cmd_valid, cmd_take, res_valid;
	cmd_t cmd;
	res_t res;

	cde_front u_front (
		.clk, .arst_n, .push, .full, .func, .site_id, .req_hash, .status, .day,
		.cmd_valid, .cmd, .cmd_take
	);

	cde_back #(.MAX_SITES(MAX_SITES), .MAX_DOMAINS(MAX_DOMAINS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .res_valid, .res, .res_pop(pop)
	);

	// result register presented as a queue head
	assign empty               = !res_valid;
	assign kind                = res.kind;
	assign row_day             = res.day;
	assign row_site            = res.site;
	assign row_domain          = res.domain;
	assign detected_count      = res.det;
	assign blocked_count       = res.blk;
	assign allowed_count       = res.alw;
	assign randomized_count    = res.rnd;
	assign dropped_site_events = res.drop;
	assign folded_events       = res.fold;
	assign last                = res.last;

endmodule

/* hw/rtl/cde_checker.sv */
// Port-level checks for the event counter, bound to the top level.
// Depends on cde_pkg.
module cde_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [31:0] row_day,
	input logic [31:0] row_site,
	input logic [31:0] row_domain,
	input logic [47:0] detected_count,
	input logic [47:0] allowed_count,
	input logic [47:0] blocked_count,
	input logic [47:0] randomized_count,
	input logic        last
);
	import cde_pkg::*;

	a_delta_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_DELTA) |-> last)
		else $error("delta beat without last");

	a_delta_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_DELTA) |->
		(row_day == 32'd0 && row_site == 32'd0 && row_domain == 32'd0 &&
		 allowed_count == 48'd0))
		else $error("delta beat carries row fields");

	a_row_width: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ROW) |->
		(detected_count[47:32] == 16'd0 && blocked_count[47:32] == 16'd0 &&
		 allowed_count[47:32] == 16'd0 && randomized_count[47:32] == 16'd0))
		else $error("row counter above 32 bits");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(last) && $stable(kind)))
		else $error("stalled result beat changed");

endmodule

bind capped_site_domain_event_counter cde_checker u_cde_checker (.*);
